FILE: src/arlt_pkg.sv
// Package for the address range lookup table: sizes, operation and register
// codes, payload structs and the token that walks the row of slot cells.
// No dependencies.
package arlt_pkg;

   localparam int SLOT_COUNT = 32;
   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int ADDR_W     = 32;
   localparam int COUNT_W    = 31;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   localparam logic CSR_DEFAULT_ADDR  = 1'b0;
   localparam logic CSR_DEFAULT_COUNT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [ADDR_W-1:0]  range_start;
      logic [ADDR_W-1:0]  range_end;
      logic [ADDR_W-1:0]  table_address_in;
      logic [COUNT_W-1:0] entry_count_in;
      logic [ADDR_W-1:0]  query_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  table_address_out;
      logic [COUNT_W-1:0] entry_count_out;
      logic               hit;
      logic               table_full;
   } rsp_type;

   // Operation token handed from cell to cell, one cell per cycle.
   typedef struct packed {
      logic                  valid;
      logic [1:0]            op;
      logic [ADDR_W-1:0]     key;
      logic                  hit;
      logic                  free_found;
      logic [SLOT_IDX_W-1:0] free_idx;
      logic [ADDR_W-1:0]     addr;
      logic [COUNT_W-1:0]    count;
   } token_type;

   // Slot write bus: data for an insert, plus a targeted write to a free slot.
   typedef struct packed {
      logic                  valid;
      logic [SLOT_IDX_W-1:0] idx;
      logic [ADDR_W-1:0]     start;
      logic [ADDR_W-1:0]     limit;
      logic [ADDR_W-1:0]     addr;
      logic [COUNT_W-1:0]    count;
   } wr_type;

endpackage

FILE: src/arlt_cell.sv
// One slot of the range table: holds start, end, table address and count,
// and updates the passing operation token. Depends on arlt_pkg.
module arlt_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [arlt_pkg::SLOT_IDX_W-1:0] cell_idx,
   input  arlt_pkg::wr_type                wr,
   input  arlt_pkg::token_type             tok_in,
   output arlt_pkg::token_type             tok_out
);

   logic [arlt_pkg::ADDR_W-1:0]  start_ff, start_in;
   logic [arlt_pkg::ADDR_W-1:0]  limit_ff;
   logic [arlt_pkg::ADDR_W-1:0]  addr_ff;
   logic [arlt_pkg::COUNT_W-1:0] count_ff;
   arlt_pkg::token_type          tok_ff, tok_in_nxt;
   logic                         data_we;

   always_comb begin
      tok_in_nxt = tok_in;
      start_in   = start_ff;
      data_we    = 1'b0;
      if (tok_in.valid) begin
         case (tok_in.op)
            arlt_pkg::OP_INSERT: begin
               if (start_ff == tok_in.key) begin
                  // replace in place; start stays the same
                  data_we        = 1'b1;
                  tok_in_nxt.hit = 1'b1;
               end else if (start_ff == '0 && !tok_in.free_found) begin
                  tok_in_nxt.free_found = 1'b1;
                  tok_in_nxt.free_idx   = cell_idx;
               end
            end
            arlt_pkg::OP_REMOVE: begin
               if (start_ff == tok_in.key) begin
                  start_in = '0;
               end
            end
            arlt_pkg::OP_LOOKUP: begin
               if (!tok_in.hit && start_ff != '0 && tok_in.key >= start_ff &&
                   tok_in.key < limit_ff) begin
                  tok_in_nxt.hit   = 1'b1;
                  tok_in_nxt.addr  = addr_ff;
                  tok_in_nxt.count = count_ff;
               end
            end
            default: begin
            end
         endcase
      end
      if (wr.valid && wr.idx == cell_idx) begin
         data_we = 1'b1;
      end
      if (data_we) begin
         start_in = wr.start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         start_ff <= start_in;
         tok_ff   <= tok_in_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         limit_ff <= wr.limit;
         addr_ff  <= wr.addr;
         count_ff <= wr.count;
      end
   end

   assign tok_out = tok_ff;

endmodule

FILE: src/address_range_table_lookup.sv
// Address range lookup table, top level: request/response control, default
// registers and the row of slot cells. Depends on arlt_pkg and arlt_cell.
//
// Usage: req_valid/req_stall carries one operation (insert, remove, lookup)
// per transaction; rsp_valid/rsp_stall returns exactly one result for each.
// csr_valid/csr_ready writes the default table address (index 0) or the
// default entry count (index 1); csr_ready is always high.
// An operation token walks the 32 slot cells at one cell per cycle: a
// lookup, insert or remove passes the launch register, the 32 cells, the
// result staging register and the output register that drives rsp_valid.
// An insert that finds no matching start writes the lowest free slot as
// the token leaves the last cell. Inserts or removes with a zero start and
// the unused operation code skip the scan and go straight to the staging
// register. One operation is in flight at a time, so a new one is accepted
// only once the previous result is staged in the output register, even
// while the receiver still stalls it.
// A stalled response holds its value. Synchronous reset frees every slot,
// clears the defaults to zero and drops any operation in flight.
module address_range_table_lookup (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  arlt_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output arlt_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [31:0]       csr_data
);

   arlt_pkg::state_type          state_ff, state_in;
   arlt_pkg::req_type            req_ff;
   arlt_pkg::token_type          inj_ff, inj_in;
   arlt_pkg::rsp_type            res_ff, res_in;
   arlt_pkg::rsp_type            rsp_ff;
   logic                         rsp_valid_ff;
   logic [arlt_pkg::ADDR_W-1:0]  dflt_addr_ff;
   logic [arlt_pkg::COUNT_W-1:0] dflt_count_ff;
   arlt_pkg::wr_type             wr;
   arlt_pkg::token_type          tok [arlt_pkg::SLOT_COUNT+1];
   logic                         accept;
   logic                         trivial;
   logic                         res_move;
   arlt_pkg::token_type          last;

   assign last = tok[arlt_pkg::SLOT_COUNT];

   assign trivial = (req_payload.op != arlt_pkg::OP_INSERT &&
                     req_payload.op != arlt_pkg::OP_REMOVE &&
                     req_payload.op != arlt_pkg::OP_LOOKUP) ||
                    (req_payload.op != arlt_pkg::OP_LOOKUP &&
                     req_payload.range_start == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         arlt_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = trivial ? arlt_pkg::ST_DONE : arlt_pkg::ST_SCAN;
            end
         end
         arlt_pkg::ST_SCAN: begin
            if (last.valid) begin
               state_in = arlt_pkg::ST_DONE;
            end
         end
         arlt_pkg::ST_DONE: begin
            if (res_move) begin
               state_in = arlt_pkg::ST_IDLE;
            end
         end
         default: state_in = arlt_pkg::ST_IDLE;
      endcase
   end

   // outputs of the controller
   always_comb begin
      req_stall = (state_ff != arlt_pkg::ST_IDLE);
      accept    = req_valid && (state_ff == arlt_pkg::ST_IDLE);
      res_move  = (state_ff == arlt_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   // launch token
   always_comb begin
      inj_in            = '0;
      inj_in.valid      = accept && !trivial;
      inj_in.op         = req_payload.op;
      inj_in.key        = (req_payload.op == arlt_pkg::OP_LOOKUP) ?
                          req_payload.query_address : req_payload.range_start;
   end

   // result staging
   always_comb begin
      res_in = res_ff;
      if (accept && trivial) begin
         res_in = '0;
      end else if (last.valid) begin
         res_in = '0;
         case (last.op)
            arlt_pkg::OP_LOOKUP: begin
               res_in.hit               = last.hit;
               res_in.table_address_out = last.hit ? last.addr : dflt_addr_ff;
               res_in.entry_count_out   = last.hit ? last.count : dflt_count_ff;
            end
            arlt_pkg::OP_INSERT: begin
               res_in.table_full = !last.hit && !last.free_found;
            end
            default: begin
            end
         endcase
      end
   end

   // insert data is held for the whole scan; the targeted write fires at the end
   always_comb begin
      wr.valid = last.valid && (last.op == arlt_pkg::OP_INSERT) &&
                 !last.hit && last.free_found;
      wr.idx   = last.free_idx;
      wr.start = req_ff.range_start;
      wr.limit = req_ff.range_end;
      wr.addr  = req_ff.table_address_in;
      wr.count = req_ff.entry_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= arlt_pkg::ST_IDLE;
         inj_ff.valid  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         dflt_addr_ff  <= '0;
         dflt_count_ff <= '0;
      end else begin
         state_ff <= state_in;
         inj_ff   <= inj_in;
         if (res_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               arlt_pkg::CSR_DEFAULT_ADDR:  dflt_addr_ff  <= csr_data;
               arlt_pkg::CSR_DEFAULT_COUNT: dflt_count_ff <= csr_data[arlt_pkg::COUNT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
      res_ff <= res_in;
      if (res_move) begin
         rsp_ff <= res_ff;
      end
   end

   assign tok[0] = inj_ff;

   for (genvar i = 0; i < arlt_pkg::SLOT_COUNT; i++) begin : g_cell
      arlt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (arlt_pkg::SLOT_IDX_W'(i)),
         .wr       (wr),
         .tok_in   (tok[i]),
         .tok_out  (tok[i+1])
      );
   end

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
